@@ rtl/ntc_adc_to_temperature_core_assert.svh @@
// Assertion macros for the thermistor conversion RTL.
`ifndef NTC_ADC_TO_TEMPERATURE_CORE_ASSERT_SVH
`define NTC_ADC_TO_TEMPERATURE_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define NTC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define NTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define NTC_ASSERT_SAME(lbl, ante, cons, msg)
`define NTC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/ntc_pkg.sv @@
// Constants, types and the calibration table of the thermistor converter.
package ntc_pkg;

  localparam int ADC_W = 16;
  localparam int TEMP_W = 11;
  localparam int ROM_POINTS = 26;
  localparam int TABLE_POINTS = 26;
  localparam int STEP_X10 = 50;
  localparam int MIN_TEMP_X10 = -400;

  localparam int N_POINTS = (TABLE_POINTS > ROM_POINTS) ? ROM_POINTS :
                            ((TABLE_POINTS < 2) ? 2 : TABLE_POINTS);
  localparam int IDX_W = $clog2(ROM_POINTS);
  localparam int STEP_W = 8;
  localparam int QW = $clog2(STEP_X10 + 1);
  localparam int NUM_W = ADC_W + QW;
  localparam int PROD_W = ADC_W + STEP_W;
  localparam int SUM_W = 17;
  localparam int K_W = (QW > 1) ? $clog2(QW) : 1;

  typedef logic [ADC_W-1:0] adc_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [QW-1:0] quo_t;
  typedef logic [NUM_W-1:0] num_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  localparam idx_t IDX_LAST = idx_t'(N_POINTS - 1);
  localparam idx_t IDX_SEARCH_END = idx_t'(N_POINTS - 2);
  localparam sum_t TEMP_MAX = sum_t'(2 ** (TEMP_W - 1) - 1);
  localparam sum_t TEMP_MIN = sum_t'(-(2 ** (TEMP_W - 1)));
  localparam sum_t STEP_S = sum_t'(STEP_X10);
  localparam sum_t MIN_TEMP_S = sum_t'(MIN_TEMP_X10);

  function automatic adc_t rom_value(input idx_t idx);
    adc_t v;
    unique case (idx)
      idx_t'(0):  v = adc_t'(6280);
      idx_t'(1):  v = adc_t'(6216);
      idx_t'(2):  v = adc_t'(6130);
      idx_t'(3):  v = adc_t'(6019);
      idx_t'(4):  v = adc_t'(5879);
      idx_t'(5):  v = adc_t'(5704);
      idx_t'(6):  v = adc_t'(5493);
      idx_t'(7):  v = adc_t'(5245);
      idx_t'(8):  v = adc_t'(4961);
      idx_t'(9):  v = adc_t'(4645);
      idx_t'(10): v = adc_t'(4303);
      idx_t'(11): v = adc_t'(3945);
      idx_t'(12): v = adc_t'(3580);
      idx_t'(13): v = adc_t'(3218);
      idx_t'(14): v = adc_t'(2868);
      idx_t'(15): v = adc_t'(2537);
      idx_t'(16): v = adc_t'(2230);
      idx_t'(17): v = adc_t'(1951);
      idx_t'(18): v = adc_t'(1700);
      idx_t'(19): v = adc_t'(1477);
      idx_t'(20): v = adc_t'(1282);
      idx_t'(21): v = adc_t'(1111);
      idx_t'(22): v = adc_t'(963);
      idx_t'(23): v = adc_t'(836);
      idx_t'(24): v = adc_t'(725);
      idx_t'(25): v = adc_t'(631);
      default:    v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/ntc_adc_to_temperature_core.sv @@
// Thermistor ADC sample to temperature converter with serial search and divide.
//
//   channel   ports                              handshake
//   command   start, busy, adc_sample            taken when start && !busy
//   result    done, in_range, temperature_x10    one-cycle strobe on done
//
// A sample outside the table gets its out-of-range result from the range check.
// A sample in interval i goes through the range check, one table compare per interval,
// one multiply, six restoring divide steps and the final sum, which raises the strobe.
// The result appears on the cycle busy falls, so the next start may be taken then.
// Reset clears the sequencer and the done strobe; in_range, temperature_x10 and the datapath are not reset.
module ntc_adc_to_temperature_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [ntc_pkg::ADC_W-1:0]         adc_sample,
  output logic                              done,
  output logic                              in_range,
  output logic signed [ntc_pkg::TEMP_W-1:0] temperature_x10
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_SEARCH = 3'd2;
  localparam logic [2:0] S_MUL    = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_SUM    = 3'd5;

  logic [2:0]                         state;
  ntc_pkg::adc_t                      sample;
  ntc_pkg::idx_t                      idx;
  ntc_pkg::sum_t                      base;
  ntc_pkg::adc_t                      span;
  ntc_pkg::adc_t                      offset;
  ntc_pkg::num_t                      rem;
  ntc_pkg::num_t                      dvs;
  ntc_pkg::quo_t                      quo;
  logic [ntc_pkg::K_W-1:0]            step_cnt;

  ntc_pkg::adc_t                      cold;
  ntc_pkg::adc_t                      warm;
  logic                               hit;
  logic [ntc_pkg::PROD_W-1:0]         prod;
  logic                               rem_ge;
  ntc_pkg::sum_t                      quo_ext;
  ntc_pkg::sum_t                      temp_full;

  assign busy = (state != S_IDLE);

  always_comb begin
    cold = ntc_pkg::rom_value(idx);
    warm = ntc_pkg::rom_value(ntc_pkg::idx_t'(idx + ntc_pkg::idx_t'(1)));
    hit = (sample <= cold) && (sample >= warm);
    prod = ntc_pkg::PROD_W'(offset) * ntc_pkg::PROD_W'(ntc_pkg::STEP_X10);
    rem_ge = (rem >= dvs);
    quo_ext = ntc_pkg::sum_t'(quo);
    temp_full = base + quo_ext;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            sample <= adc_sample;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          idx <= '0;
          base <= ntc_pkg::MIN_TEMP_S;
          if ((sample <= ntc_pkg::rom_value('0)) &&
              (sample >= ntc_pkg::rom_value(ntc_pkg::IDX_LAST))) begin
            state <= S_SEARCH;
          end else begin
            in_range <= 1'b0;
            temperature_x10 <= '0;
            done <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_SEARCH: begin
          if (hit) begin
            span <= cold - warm;
            offset <= cold - sample;
            state <= S_MUL;
          end else if (idx == ntc_pkg::IDX_SEARCH_END) begin
            in_range <= 1'b0;
            temperature_x10 <= '0;
            done <= 1'b1;
            state <= S_IDLE;
          end else begin
            idx <= ntc_pkg::idx_t'(idx + ntc_pkg::idx_t'(1));
            base <= base + ntc_pkg::STEP_S;
          end
        end
        S_MUL: begin
          rem <= ntc_pkg::num_t'(prod) + ntc_pkg::num_t'(span >> 1);
          dvs <= ntc_pkg::num_t'(span) << (ntc_pkg::QW - 1);
          quo <= '0;
          step_cnt <= ntc_pkg::K_W'(ntc_pkg::QW - 1);
          if (span == '0) begin
            state <= S_SUM;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem_ge) begin
            rem <= rem - dvs;
          end
          quo <= ntc_pkg::quo_t'({quo, rem_ge});
          dvs <= dvs >> 1;
          step_cnt <= step_cnt - ntc_pkg::K_W'(1);
          if (step_cnt == '0) begin
            state <= S_SUM;
          end
        end
        S_SUM: begin
          in_range <= 1'b1;
          priority if (temp_full > ntc_pkg::TEMP_MAX) begin
            temperature_x10 <= ntc_pkg::TEMP_W'(ntc_pkg::TEMP_MAX);
          end else if (temp_full < ntc_pkg::TEMP_MIN) begin
            temperature_x10 <= ntc_pkg::TEMP_W'(ntc_pkg::TEMP_MIN);
          end else begin
            temperature_x10 <= ntc_pkg::TEMP_W'(temp_full);
          end
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`include "ntc_adc_to_temperature_core_assert.svh"

  `NTC_ASSERT_SAME(a_done_not_busy, done, !busy, "result strobe while still busy")
  `NTC_ASSERT_SAME(a_out_of_range_zero, done && !in_range,
                   temperature_x10 == '0, "out of range result is not zero")
  `NTC_ASSERT_NEXT(a_start_goes_busy, start && !busy, busy,
                   "accepted transaction did not raise busy")
  `NTC_ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")
  `NTC_ASSERT_SAME(a_quo_bound, state == S_SUM,
                   quo <= ntc_pkg::quo_t'(ntc_pkg::STEP_X10), "interpolation exceeds one step")

endmodule
